// ===== sv/mxcalc_pkg.sv =====
// Shared types and constants for the 4x4 matrix add, subtract and multiply block.
package mxcalc_pkg;

    // Operation codes held in the configuration register.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } op_t;

    // Control word that travels with each stored element through the queue.
    typedef struct packed {
        logic sel_b;    // element belongs to matrix B
        logic last;     // final element of B, starts the compute phase
        op_t  op;       // operation sampled with the final element
    } ctl_t;

    localparam int ELEM_W      = 32;
    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== sv/mxcalc_front.sv =====
// Front end: accepts elements, tracks the load position and tags each store command.
module mxcalc_front #(
    parameter int  DIM   = 4,
    localparam int CELLS = DIM * DIM,
    localparam int IDX_W = $clog2(CELLS),
    localparam int CNT_W = $clog2(2 * CELLS)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [mxcalc_pkg::ELEM_W-1:0] s_element,
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_wr_data,
    input  logic                                q_full,
    output logic                                q_push,
    output mxcalc_pkg::ctl_t                    q_ctl,
    output logic [IDX_W-1:0]                    q_addr,
    output logic [mxcalc_pkg::ELEM_W-1:0]       q_data
);
    import mxcalc_pkg::*;

    logic [CNT_W-1:0] count_reg;
    op_t              op_reg;
    logic             is_b;
    logic             is_last;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;
    assign is_b    = (32'(count_reg) >= CELLS);
    assign is_last = (32'(count_reg) == 2 * CELLS - 1);

    assign q_ctl.sel_b = is_b;
    assign q_ctl.last  = is_last;
    assign q_ctl.op    = op_reg;
    assign q_addr      = is_b ? IDX_W'(32'(count_reg) - CELLS) : IDX_W'(count_reg);
    assign q_data      = s_element;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            op_reg    <= OP_ADD;
        end else begin
            if (cfg_wr_en) begin
                op_reg <= op_t'(cfg_wr_data);
            end
            if (q_push) begin
                if (is_last) begin
                    count_reg <= '0;
                end else begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/mxcalc_fifo.sv =====
// Small show-ahead queue that decouples the front end from the compute engine.
module mxcalc_fifo #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (32'(fill_reg) == DEPTH);
    assign not_empty = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/mxcalc_back.sv =====
// Compute engine: stores both matrices and produces result cells on one shared unit.
module mxcalc_back #(
    parameter int  DIM   = 4,
    localparam int CELLS = DIM * DIM,
    localparam int IDX_W = $clog2(CELLS),
    localparam int DW    = $clog2(DIM)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  mxcalc_pkg::ctl_t                     q_ctl,
    input  logic [IDX_W-1:0]                     q_addr,
    input  logic [mxcalc_pkg::ELEM_W-1:0]        q_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [mxcalc_pkg::ELEM_W-1:0] m_result,
    output logic [1:0]                           m_row,
    output logic [1:0]                           m_column,
    output logic                                 m_last
);
    import mxcalc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_ACC,
        S_OUT
    } state_t;

    logic [ELEM_W-1:0] mem_a [CELLS];
    logic [ELEM_W-1:0] mem_b [CELLS];

    state_t            state_reg;
    op_t               op_reg;
    logic [DW-1:0]     r_reg;
    logic [DW-1:0]     c_reg;
    logic [DW-1:0]     j_reg;
    logic [ELEM_W-1:0] a_q_reg;
    logic [ELEM_W-1:0] b_q_reg;
    logic [ELEM_W-1:0] term_reg;
    logic [ELEM_W-1:0] acc_reg;
    logic              m_valid_reg;
    logic [ELEM_W-1:0] m_result_reg;
    logic [1:0]        m_row_reg;
    logic [1:0]        m_column_reg;
    logic              m_last_reg;

    logic [DW-1:0]     a_col;
    logic [DW-1:0]     b_row;
    logic [IDX_W-1:0]  a_addr;
    logic [IDX_W-1:0]  b_addr;
    logic [ELEM_W-1:0] term_next;
    logic [ELEM_W-1:0] acc_next;
    logic              is_mul;
    logic              last_cell;

    assign q_ready   = (state_reg == S_IDLE);
    assign is_mul    = (op_reg == OP_MUL);
    assign last_cell = (32'(r_reg) == DIM - 1) && (32'(c_reg) == DIM - 1);

    // For the product, A walks along row r and B walks down column c.
    assign a_col  = is_mul ? j_reg : c_reg;
    assign b_row  = is_mul ? j_reg : r_reg;
    assign a_addr = IDX_W'(32'(r_reg) * DIM + 32'(a_col));
    assign b_addr = IDX_W'(32'(b_row) * DIM + 32'(c_reg));

    always_comb begin
        unique case (op_reg)
            OP_ADD:  term_next = a_q_reg + b_q_reg;
            OP_SUB:  term_next = a_q_reg - b_q_reg;
            OP_MUL:  term_next = a_q_reg * b_q_reg;
            default: term_next = '0;
        endcase
    end

    assign acc_next = acc_reg + term_reg;

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            if (q_ctl.sel_b) begin
                mem_b[q_addr] <= q_data;
            end else begin
                mem_a[q_addr] <= q_data;
            end
        end
        a_q_reg <= mem_a[a_addr];
        b_q_reg <= mem_b[b_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_ADD;
            r_reg       <= '0;
            c_reg       <= '0;
            j_reg       <= '0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // In S_OUT the output register is reloaded instead when the result is taken.
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_ctl.last) begin
                        op_reg    <= q_ctl.op;
                        r_reg     <= '0;
                        c_reg     <= '0;
                        j_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_CALC;
                end
                S_CALC: begin
                    term_reg  <= term_next;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg <= acc_next;
                    if (is_mul && (32'(j_reg) != DIM - 1)) begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_READ;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_result_reg <= acc_reg;
                        m_row_reg    <= 2'(r_reg);
                        m_column_reg <= 2'(c_reg);
                        m_last_reg   <= last_cell;
                        acc_reg      <= '0;
                        j_reg        <= '0;
                        if (last_cell) begin
                            state_reg <= S_IDLE;
                        end else begin
                            if (32'(c_reg) == DIM - 1) begin
                                c_reg <= '0;
                                r_reg <= r_reg + 1'b1;
                            end else begin
                                c_reg <= c_reg + 1'b1;
                            end
                            state_reg <= S_READ;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;
    assign m_row    = m_row_reg;
    assign m_column = m_column_reg;
    assign m_last   = m_last_reg;

endmodule

// ===== sv/matrix_add_sub_mul_4x4_top.sv =====
// Matrix calculator: loads A then B row-major, one element per item, and returns
// A+B, A-B or the product A*B row-major, wrapping to 32 bits. Loading takes one item
// per cycle while the queue between the front end and the compute engine has room.
// Once the final element of B reaches the engine, it computes the DIM*DIM result
// cells one after another on a single add, subtract, multiply and accumulate unit
// fed by registered memory reads: each cell runs read, calc and accumulate steps,
// once per product term or once for add or subtract, then an output step that waits
// for the output register. Elements may still be accepted until the queue fills. The operation
// is taken with the final element of B; code 3 yields zero results.
module matrix_add_sub_mul_4x4_top #(
    parameter int DIM = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [mxcalc_pkg::ELEM_W-1:0] s_element,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [mxcalc_pkg::ELEM_W-1:0] m_result,
    output logic [1:0]                           m_row,
    output logic [1:0]                           m_column,
    output logic                                 m_last,
    input  logic                                 cfg_wr_en,
    input  logic [1:0]                           cfg_wr_data
);
    import mxcalc_pkg::*;

    localparam int IDX_W = $clog2(DIM * DIM);
    localparam int CTL_W = $bits(ctl_t);
    localparam int Q_W   = CTL_W + IDX_W + ELEM_W;

    logic              q_full;
    logic              q_push;
    ctl_t              f_ctl;
    logic [IDX_W-1:0]  f_addr;
    logic [ELEM_W-1:0] f_data;
    logic              q_not_empty;
    logic              q_pop;
    logic [Q_W-1:0]    q_out;
    ctl_t              b_ctl;
    logic [IDX_W-1:0]  b_addr;
    logic [ELEM_W-1:0] b_data;

    mxcalc_front #(.DIM(DIM)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_element   (s_element),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_ctl       (f_ctl),
        .q_addr      (f_addr),
        .q_data      (f_data)
    );

    mxcalc_fifo #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_ctl, f_addr, f_data}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    assign b_ctl  = ctl_t'(q_out[Q_W-1 -: CTL_W]);
    assign b_addr = q_out[ELEM_W +: IDX_W];
    assign b_data = q_out[ELEM_W-1:0];

    mxcalc_back #(.DIM(DIM)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_ready  (q_pop),
        .q_ctl    (b_ctl),
        .q_addr   (b_addr),
        .q_data   (b_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result),
        .m_row    (m_row),
        .m_column (m_column),
        .m_last   (m_last)
    );

endmodule
